[hw/rtl/periodic_ard_kernel_element_core_defines.svh]
// assertion macros for the periodic ard kernel element core
// no dependencies; included by the files that carry assertions
`ifndef PERIODIC_ARD_KERNEL_ELEMENT_CORE_DEFINES_SVH
`define PERIODIC_ARD_KERNEL_ELEMENT_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PARD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PARD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pard_pkg.sv]
// constants, tables and helper functions for the periodic ard kernel element
// no dependencies; used by pard_lane and periodic_ard_kernel_element_core
package pard_pkg;

  localparam int unsigned DIM_MAX     = 3;
  localparam int unsigned DIM_DEFAULT = 3;

  // pipeline shape
  localparam int unsigned RED_STEPS = 45;
  localparam int unsigned SIN_STEPS = 5;
  localparam int unsigned EXP_STEPS = 10;
  localparam int unsigned LANE_LAT  = 3 + RED_STEPS + 2 + 3 * SIN_STEPS + 4;
  localparam int unsigned CORE_LAT  = 1 + LANE_LAT + 4 + 3 * EXP_STEPS + 3;

  // phase reduction
  localparam int unsigned PHASE_W = 94;
  localparam int unsigned TAIL_W  = 45;
  localparam logic [49:0] PI_Q48  = 50'h3243F6A8885A3;
  localparam logic [49:0] PI_HALF = PI_Q48 >> 1;

  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [32:0] ONE32 = 33'h1_0000_0000;

  localparam logic [31:0] LOG2E_FRAC = 32'h7154_7653;
  localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;

  localparam int unsigned TERM_W = 39;
  localparam logic [TERM_W-1:0] R2_CAP = 39'h40_0000_0000;

  // sine horner divisors and their reciprocals in q32
  localparam logic [6:0] SIN_DIV [SIN_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
    32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
    32'((64'd1 << 32) / 20),  32'((64'd1 << 32) / 6)
  };

  // exp horner reciprocals for divisors ten down to one
  localparam logic [31:0] EXP_RECIP [EXP_STEPS] = '{
    32'((64'd1 << 32) / 10), 32'((64'd1 << 32) / 9), 32'((64'd1 << 32) / 8),
    32'((64'd1 << 32) / 7),  32'((64'd1 << 32) / 6), 32'((64'd1 << 32) / 5),
    32'((64'd1 << 32) / 4),  32'((64'd1 << 32) / 3), 32'((64'd1 << 32) / 2),
    32'hFFFF_FFFF
  };

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_2    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS      = 3'd7;

  // magnitude of a two's complement word
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // fix a reciprocal quotient estimate that may be one short
  function automatic logic [31:0] div_fix(input logic [31:0] q, input logic [31:0] est,
                                          input logic [6:0] d);
    logic [38:0] prod;
    logic [31:0] rem;
    prod = {7'b0, est} * {32'b0, d};
    rem  = q - prod[31:0];
    return (rem >= {25'b0, d}) ? est + 32'd1 : est;
  endfunction

endpackage

[hw/rtl/pard_lane.sv]
// one dimension of the kernel: weighted sin^2 of the scaled coordinate difference
// depends on pard_pkg
module pard_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [31:0]            in_a,
  input  logic signed [31:0]            in_b,
  input  logic [63:0]                   freq_sq,
  input  logic [63:0]                   scale_sq,
  output logic                          out_valid,
  output logic [pard_pkg::TERM_W-1:0]   out_term
);
  import pard_pkg::*;

  // difference magnitude
  logic [32:0] diff;
  logic [31:0] dm_nxt;
  logic [31:0] dm_r;
  logic        v1_r;

  assign diff   = {in_a[31], in_a} - {in_b[31], in_b};
  assign dm_nxt = diff[32] ? 32'(~diff + 33'd1) : diff[31:0];

  // phase partial products
  logic [62:0] p1_r;
  logic [63:0] p0_r;
  logic        v2_r;

  // full phase
  logic [94:0]          ph_nxt;
  logic [PHASE_W-1:0]   ph_r;
  logic                 v3_r;

  assign ph_nxt = {p1_r, 32'b0} + {31'b0, p0_r};

  always_ff @(posedge clk) begin
    dm_r <= dm_nxt;
    p1_r <= {32'b0, freq_sq[62:32]} * {31'b0, dm_r};
    p0_r <= {32'b0, freq_sq[31:0]} * {32'b0, dm_r};
    ph_r <= ph_nxt[PHASE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // restoring reduction modulo pi, one phase bit per stage
  logic [49:0]       red   [0:RED_STEPS];
  logic [TAIL_W-1:0] tail  [0:RED_STEPS-1];
  logic              red_v [0:RED_STEPS];

  assign red[0]   = {1'b0, ph_r[PHASE_W-1:TAIL_W]};
  assign tail[0]  = ph_r[TAIL_W-1:0];
  assign red_v[0] = v3_r;

  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    logic [50:0] rr;
    logic [50:0] rr_nxt;
    logic [49:0] red_r;
    logic        rv_r;

    assign rr     = {red[j], tail[j][TAIL_W-1]};
    assign rr_nxt = (rr >= {1'b0, PI_Q48}) ? rr - {1'b0, PI_Q48} : rr;

    always_ff @(posedge clk) begin
      red_r <= rr_nxt[49:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r <= 1'b0;
      end else begin
        rv_r <= red_v[j];
      end
    end

    assign red[j+1]   = red_r;
    assign red_v[j+1] = rv_r;

    if (j < RED_STEPS - 1) begin : g_tail
      logic [TAIL_W-1:0] tail_r;
      always_ff @(posedge clk) begin
        tail_r <= {tail[j][TAIL_W-2:0], 1'b0};
      end
      assign tail[j+1] = tail_r;
    end
  end

  // fold into the first quarter period, then x and x^2 in q30
  logic [49:0] rm;
  logic [30:0] x_r;
  logic        vx_r;
  logic [61:0] xx;
  logic [31:0] x2_r;
  logic [30:0] xq_r;
  logic        vq_r;

  assign rm = (red[RED_STEPS] > PI_HALF) ? PI_Q48 - red[RED_STEPS] : red[RED_STEPS];
  assign xx = {31'b0, x_r} * {31'b0, x_r};

  always_ff @(posedge clk) begin
    x_r  <= rm[48:18];
    x2_r <= xx[61:30];
    xq_r <= x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= 1'b0;
      vq_r <= 1'b0;
    end else begin
      vx_r <= red_v[RED_STEPS];
      vq_r <= vx_r;
    end
  end

  // sine series by horner, three stages per term
  logic [30:0] h_t  [0:SIN_STEPS];
  logic [30:0] h_x  [0:SIN_STEPS];
  logic [31:0] h_x2 [0:SIN_STEPS-1];
  logic        h_v  [0:SIN_STEPS];

  assign h_t[0]  = ONE30;
  assign h_x[0]  = xq_r;
  assign h_x2[0] = x2_r;
  assign h_v[0]  = vq_r;

  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    logic [62:0] prod_a;
    logic [63:0] prod_b;
    logic [31:0] quot_c;
    logic [31:0] qa_r, qb_r, est_r;
    logic [30:0] xa_r, xb_r, xc_r, tc_r;
    logic [31:0] x2a_r, x2b_r;
    logic        va_r, vb_r, vc_r;

    assign prod_a = {31'b0, h_x2[i]} * {32'b0, h_t[i]};
    assign prod_b = {32'b0, qa_r} * {32'b0, SIN_RECIP[i]};
    assign quot_c = div_fix(qb_r, est_r, SIN_DIV[i]);

    always_ff @(posedge clk) begin
      qa_r  <= prod_a[61:30];
      xa_r  <= h_x[i];
      x2a_r <= h_x2[i];
      qb_r  <= qa_r;
      est_r <= prod_b[63:32];
      xb_r  <= xa_r;
      x2b_r <= x2a_r;
      tc_r  <= ONE30 - quot_c[30:0];
      xc_r  <= xb_r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r <= 1'b0;
        vb_r <= 1'b0;
        vc_r <= 1'b0;
      end else begin
        va_r <= h_v[i];
        vb_r <= va_r;
        vc_r <= vb_r;
      end
    end

    assign h_t[i+1] = tc_r;
    assign h_x[i+1] = xc_r;
    assign h_v[i+1] = vc_r;

    if (i < SIN_STEPS - 1) begin : g_x2
      logic [31:0] x2c_r;
      always_ff @(posedge clk) begin
        x2c_r <= x2b_r;
      end
      assign h_x2[i+1] = x2c_r;
    end
  end

  // sine, its square, then the weighted term
  logic [61:0] xs;
  logic [31:0] s_raw;
  logic [30:0] s_r;
  logic [61:0] ss;
  logic [30:0] s2_r;
  logic [61:0] wh_r;
  logic [62:0] wl_r;
  logic [63:0] w_sum;
  logic [TERM_W-1:0] term_r;
  logic        vs_r, vs2_r, vw_r, vt_r;

  assign xs    = {31'b0, h_x[SIN_STEPS]} * {31'b0, h_t[SIN_STEPS]};
  assign s_raw = xs[61:30];
  assign ss    = {31'b0, s_r} * {31'b0, s_r};
  assign w_sum = {wh_r, 2'b0} + {31'b0, wl_r[62:30]};

  always_ff @(posedge clk) begin
    s_r    <= (s_raw > {1'b0, ONE30}) ? ONE30 : s_raw[30:0];
    s2_r   <= ss[60:30];
    wh_r   <= {31'b0, scale_sq[62:32]} * {31'b0, s2_r};
    wl_r   <= {31'b0, scale_sq[31:0]} * {32'b0, s2_r};
    term_r <= (w_sum > {25'b0, R2_CAP}) ? R2_CAP : w_sum[TERM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r  <= 1'b0;
      vs2_r <= 1'b0;
      vw_r  <= 1'b0;
      vt_r  <= 1'b0;
    end else begin
      vs_r  <= h_v[SIN_STEPS];
      vs2_r <= vs_r;
      vw_r  <= vs2_r;
      vt_r  <= vw_r;
    end
  end

  assign out_valid = vt_r;
  assign out_term  = term_r;

endmodule

[hw/rtl/periodic_ard_kernel_element_core.sv]
// periodic ard kernel element: one kernel value per accepted request, flagged by out_valid
// throughput one request per cycle, set by a fully pipelined datapath with no feedback
// the longest part is the 45-stage modulo-pi phase reduction in each dimension lane
// busy is high only during reset; results appear for one cycle and cannot be stalled
// synchronous active-low reset restores the register defaults and drops all valid bits
// depends on pard_pkg, pard_lane and periodic_ard_kernel_element_core_defines.svh
`include "periodic_ard_kernel_element_core_defines.svh"

module periodic_ard_kernel_element_core #(
  parameter int unsigned DIM = pard_pkg::DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                in_point_a_0,
  input  logic signed [31:0]                in_point_a_1,
  input  logic signed [31:0]                in_point_a_2,
  input  logic signed [31:0]                in_point_b_0,
  input  logic signed [31:0]                in_point_b_1,
  input  logic signed [31:0]                in_point_b_2,
  // result channel
  output logic                              out_valid,
  output logic [31:0]                       out_kernel_value,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [pard_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import pard_pkg::*;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] amplitude_r;
  logic [31:0] scale_r [DIM_MAX];
  logic [31:0] freq_r  [DIM_MAX];
  logic [1:0]  dims_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= 32'h0001_0000;
      for (int k = 0; k < DIM_MAX; k++) begin
        scale_r[k] <= 32'h0001_0000;
        freq_r[k]  <= 32'h0001_0000;
      end
      dims_r <= 2'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_AMPLITUDE: amplitude_r <= cfg_data;
        REG_SCALE_0:   scale_r[0]  <= cfg_data;
        REG_SCALE_1:   scale_r[1]  <= cfg_data;
        REG_SCALE_2:   scale_r[2]  <= cfg_data;
        REG_FREQ_0:    freq_r[0]   <= cfg_data;
        REG_FREQ_1:    freq_r[1]   <= cfg_data;
        REG_FREQ_2:    freq_r[2]   <= cfg_data;
        REG_DIMS:      dims_r      <= cfg_data[1:0];
        default:       dims_r      <= dims_r;
      endcase
    end
  end

  // squares of the weights are only ever used, so keep them registered;
  // they settle in the cycle after a write lands, well before any request needs them
  logic [31:0] amp_mag;
  logic [63:0] amp_sq_r;
  logic [63:0] freq_sq_r  [DIM];
  logic [63:0] scale_sq_r [DIM];

  assign amp_mag = mag32(amplitude_r);

  always_ff @(posedge clk) begin
    amp_sq_r <= {32'b0, amp_mag} * {32'b0, amp_mag};
  end

  for (genvar k = 0; k < DIM; k++) begin : g_sq
    logic [31:0] fm, sm;
    assign fm = mag32(freq_r[k]);
    assign sm = mag32(scale_r[k]);
    always_ff @(posedge clk) begin
      freq_sq_r[k]  <= {32'b0, fm} * {32'b0, fm};
      scale_sq_r[k] <= {32'b0, sm} * {32'b0, sm};
    end
  end

  // dimensions in use: zero counts as one, and never more than the lanes built
  logic [1:0] dims_eff;
  assign dims_eff = (dims_r == 2'd0) ? 2'd1 :
                    (dims_r > 2'(DIM)) ? 2'(DIM) : dims_r;

  // ---------------------------------------------------------------------------
  // request capture
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic in_v_r;
  logic signed [31:0] a_r [DIM_MAX];
  logic signed [31:0] b_r [DIM_MAX];

  assign busy   = !rst_n;
  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    a_r[0] <= in_point_a_0;
    a_r[1] <= in_point_a_1;
    a_r[2] <= in_point_a_2;
    b_r[0] <= in_point_b_0;
    b_r[1] <= in_point_b_1;
    b_r[2] <= in_point_b_2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_acc;
    end
  end

  // ---------------------------------------------------------------------------
  // one lane per dimension; lanes run in lock step
  // ---------------------------------------------------------------------------
  logic [TERM_W-1:0] term   [DIM_MAX];
  logic              lane_v [DIM];

  for (genvar k = 0; k < DIM_MAX; k++) begin : g_lane
    if (k < DIM) begin : g_on
      logic [TERM_W-1:0] lt;
      pard_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_v_r),
        .in_a      (a_r[k]),
        .in_b      (b_r[k]),
        .freq_sq   (freq_sq_r[k]),
        .scale_sq  (scale_sq_r[k]),
        .out_valid (lane_v[k]),
        .out_term  (lt)
      );
      // unused dimensions drop out of the sum
      assign term[k] = (2'(k) < dims_eff) ? lt : '0;
    end else begin : g_off
      assign term[k] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // saturating sum of the terms, then y = r2 * log2(e)
  // ---------------------------------------------------------------------------
  logic [TERM_W+1:0] r2_sum;
  logic [TERM_W-1:0] r2_r;
  logic              e1_v_r;

  assign r2_sum = {2'b0, term[0]} + {2'b0, term[1]} + {2'b0, term[2]};

  logic [6:0]  rh_r;
  logic [31:0] rl_r;
  logic [38:0] rhl_r;
  logic [63:0] rll_r;
  logic        e2_v_r;

  logic [40:0] y_nxt;
  logic [6:0]  n3_r;
  logic [31:0] f_r;
  logic        e3_v_r;

  logic [63:0] fl;
  logic [31:0] g_r;
  logic [6:0]  n4_r;
  logic        e4_v_r;

  assign y_nxt = {2'b0, rh_r, 32'b0} + {2'b0, rhl_r} + {9'b0, rl_r} + {9'b0, rll_r[63:32]};
  assign fl    = {32'b0, f_r} * {32'b0, LN2_Q32};

  always_ff @(posedge clk) begin
    r2_r  <= (r2_sum > {2'b0, R2_CAP}) ? R2_CAP : r2_sum[TERM_W-1:0];
    rh_r  <= r2_r[38:32];
    rl_r  <= r2_r[31:0];
    rhl_r <= {32'b0, r2_r[38:32]} * {7'b0, LOG2E_FRAC};
    rll_r <= {32'b0, r2_r[31:0]} * {32'b0, LOG2E_FRAC};
    n3_r  <= y_nxt[38:32];
    f_r   <= y_nxt[31:0];
    g_r   <= fl[63:32];
    n4_r  <= n3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
      e4_v_r <= 1'b0;
    end else begin
      e1_v_r <= lane_v[0];
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
      e4_v_r <= e3_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // exp(-g) by horner over divisors ten down to one, three stages per term
  // ---------------------------------------------------------------------------
  logic [32:0] ex_e [0:EXP_STEPS];
  logic [31:0] ex_g [0:EXP_STEPS-1];
  logic [6:0]  ex_n [0:EXP_STEPS];
  logic        ex_v [0:EXP_STEPS];

  assign ex_e[0] = ONE32;
  assign ex_g[0] = g_r;
  assign ex_n[0] = n4_r;
  assign ex_v[0] = e4_v_r;

  for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
    logic [64:0] prod_a;
    logic [63:0] prod_b;
    logic [31:0] quot_c;
    logic [31:0] qa_r, qb_r, est_r;
    logic [31:0] ga_r, gb_r;
    logic [6:0]  na_r, nb_r, nc_r;
    logic [32:0] ec_r;
    logic        va_r, vb_r, vc_r;

    assign prod_a = {33'b0, ex_g[j]} * {32'b0, ex_e[j]};
    assign prod_b = {32'b0, qa_r} * {32'b0, EXP_RECIP[j]};
    assign quot_c = div_fix(qb_r, est_r, 7'(EXP_STEPS - j));

    always_ff @(posedge clk) begin
      qa_r  <= prod_a[63:32];
      ga_r  <= ex_g[j];
      na_r  <= ex_n[j];
      qb_r  <= qa_r;
      est_r <= prod_b[63:32];
      gb_r  <= ga_r;
      nb_r  <= na_r;
      ec_r  <= ONE32 - {1'b0, quot_c};
      nc_r  <= nb_r;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r <= 1'b0;
        vb_r <= 1'b0;
        vc_r <= 1'b0;
      end else begin
        va_r <= ex_v[j];
        vb_r <= va_r;
        vc_r <= vb_r;
      end
    end

    assign ex_e[j+1] = ec_r;
    assign ex_n[j+1] = nc_r;
    assign ex_v[j+1] = vc_r;

    if (j < EXP_STEPS - 1) begin : g_gc
      logic [31:0] gc_r;
      always_ff @(posedge clk) begin
        gc_r <= gb_r;
      end
      assign ex_g[j+1] = gc_r;
    end
  end

  // ---------------------------------------------------------------------------
  // scale by amplitude^2, shift down by 16 + n and saturate
  // ---------------------------------------------------------------------------
  logic [63:0] ah_r;
  logic [32:0] al_r;
  logic [6:0]  n5_r;
  logic        f1_v_r;
  logic [64:0] al_full;

  logic [63:0] hi_r;
  logic [7:0]  sh_r;
  logic        f2_v_r;

  logic [63:0] hi_sh;
  logic [31:0] out_r;
  logic        f3_v_r;

  assign al_full = {33'b0, amp_sq_r[31:0]} * {32'b0, ex_e[EXP_STEPS]};
  assign hi_sh   = hi_r >> sh_r[5:0];

  always_ff @(posedge clk) begin
    ah_r  <= {33'b0, amp_sq_r[62:32]} * {31'b0, ex_e[EXP_STEPS]};
    al_r  <= al_full[64:32];
    n5_r  <= ex_n[EXP_STEPS];
    hi_r  <= ah_r + {31'b0, al_r};
    sh_r  <= 8'd16 + {1'b0, n5_r};
    // a shift of the whole word or more leaves nothing
    if (sh_r >= 8'd64) begin
      out_r <= '0;
    end else begin
      out_r <= (hi_sh[63:32] != 32'd0) ? 32'hFFFF_FFFF : hi_sh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else begin
      f1_v_r <= ex_v[EXP_STEPS];
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  assign out_valid        = f3_v_r;
  assign out_kernel_value = out_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `PARD_ASSERT_IMP(a_fixed_latency, clk, rst_n, 1'b1, out_valid == ($past(in_acc, CORE_LAT) === 1'b1), "result strobe off the pipeline latency")
  `PARD_ASSERT_IMP(a_lanes_aligned, clk, rst_n, 1'b1, lane_v[0] == lane_v[DIM-1], "dimension lanes out of step")
  `PARD_ASSERT_IMP(a_r2_capped, clk, rst_n, e1_v_r, r2_r <= R2_CAP, "r2 sum above its cap")
  `PARD_ASSERT_IMP(a_g_range, clk, rst_n, e4_v_r, g_r < LN2_Q32, "exp argument outside one octave")
  `PARD_ASSERT_NXT(a_deep_shift, clk, rst_n, f2_v_r && (sh_r >= 8'd64), out_valid && (out_kernel_value == 32'd0), "deep shift did not give zero")

endmodule
